// ===== hdl/drm_pkg.sv =====
// Package for the drop rate meter: register indexes, operation codes,
// arithmetic constants and the divider request type. No dependencies.
package drm_pkg;

  localparam logic [2:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [2:0] REG_MIN_INT   = 3'd1;
  localparam logic [2:0] REG_WINDOW    = 3'd2;
  localparam logic [2:0] REG_TIMEOUT   = 3'd3;
  localparam logic [2:0] REG_TARGET    = 3'd4;
  localparam logic [2:0] REG_TOLERANCE = 3'd5;

  localparam logic [1:0] FUNC_QUERY = 2'd0;
  localparam logic [1:0] FUNC_DROP  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [23:0] MIN_SCALED = 24'd15360000;
  localparam logic [23:0] RATE_MAX   = 24'hFFFFFF;
  localparam logic [23:0] FLOW_LIMIT = 24'd128;
  localparam logic [6:0]  PCT_FULL   = 7'd100;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

// ===== hdl/drm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the drop rate meter.
// Depends on drm_pkg for the request type.
module drm_div (
  input  logic              clk,
  input  logic              rst,
  input  drm_pkg::div_req_t req,
  output logic              busy,
  output logic              done,
  output logic [31:0]       quotient
);
  import drm_pkg::*;

  logic [32:0] rem;
  logic [31:0] quo;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic [32:0] trial;

  assign trial    = {rem[31:0], quo[31]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= 33'd0;
        quo  <= req.dividend;
        dsr  <= req.divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= trial - {1'b0, dsr};
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/drop_rate_meter_unit.sv =====
// Top level of the drop rate meter: stamp memory, scan sequencer and result register.
// Depends on drm_pkg and drm_div.
//
// Channel | Direction | Transfer content
// s       | in        | tdata now_ms, tuser func
// m       | out       | tdata result fields
// cfg     | in        | register write, index and data
//
// An item that needs a divide goes from one accepting edge to the next through the
// accepting idle cycle, the update step, the walk over the stamp memory at one read a
// cycle, the multiply step, the divider and the finish step. An item without a divide
// skips the divider.
// Reset restores the configuration, the control state and the meter state; the stamps carry
// valid bits cleared at once.
// A result waiting on m holds the sequencer in its last step until transferred.
module drop_rate_meter_unit #(
  parameter int RING_DEPTH = 60
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,  // [31:0] now_ms
  input  logic [1:0]   s_tuser,  // [1:0] func
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] accepted, [32:1] drop_count, [38:33] drops_in_window, [62:39] rate_q8,
  // [63] flowing, [64] stopped, [65] in_target, [97:66] since_last_ms, rest zero
  output logic [103:0] m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);
  import drm_pkg::*;

  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int NW = $clog2(RING_DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [15:0] debounce_ms, min_interval_ms;
  logic [19:0] window_ms, timeout_ms;
  logic [23:0] target_rate_q8;
  logic [6:0]  tolerance_pct;

  logic [31:0] stamp_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] stamp_vld;
  logic [IW-1:0] write_slot;
  logic [31:0] last_accept_time, accept_total;

  logic [2:0]  state;
  logic [1:0]  func;
  logic [31:0] now;
  logic        accepted;
  logic [NW-1:0] scan_cnt, n;
  logic        pend;
  logic [31:0] rd_data;
  logic        rd_vld;
  logic [31:0] oldest;
  logic        use_div;
  logic [23:0] rate;
  div_req_t    dreq;
  logic        div_busy, div_done;
  logic [31:0] div_q;

  logic [15:0] limit;
  logic [31:0] gap, since, span;
  logic        mem_we;
  logic        hit;
  logic [30:0] lhs;
  logic [31:0] lo, hi;
  logic        in_target;

  assign s_tready = (state == ST_IDLE);
  assign limit    = (debounce_ms > min_interval_ms) ? debounce_ms : min_interval_ms;
  assign gap      = now - last_accept_time;
  assign since    = (last_accept_time == 32'd0) ? 32'hFFFFFFFF : gap;
  assign span     = now - oldest;
  assign mem_we   = (state == ST_UPD) && (func == FUNC_DROP) &&
                    ((now - last_accept_time) >= {16'd0, limit});
  assign hit      = rd_vld && (rd_data != 32'd0) && ((now - rd_data) <= {12'd0, window_ms});
  assign lhs      = 31'(rate) * 31'd100;
  assign hi       = 32'(target_rate_q8) * 32'(PCT_FULL + {1'b0, tolerance_pct});
  assign lo       = (tolerance_pct >= PCT_FULL) ? 32'd0 :
                    32'(target_rate_q8) * 32'(PCT_FULL - tolerance_pct);
  assign in_target = ({1'b0, lhs} >= lo) && ({1'b0, lhs} <= hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= 16'd50;
      min_interval_ms <= 16'd100;
      window_ms       <= 20'd60000;
      timeout_ms      <= 20'd10000;
      target_rate_q8  <= 24'd15360;
      tolerance_pct   <= 7'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:  debounce_ms     <= cfg_data[15:0];
        REG_MIN_INT:   min_interval_ms <= cfg_data[15:0];
        REG_WINDOW:    window_ms       <= cfg_data[19:0];
        REG_TIMEOUT:   timeout_ms      <= cfg_data[19:0];
        REG_TARGET:    target_rate_q8  <= cfg_data;
        REG_TOLERANCE: tolerance_pct   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stamp_mem[write_slot] <= now;
    end
    if (state == ST_SCAN && scan_cnt < NW'(RING_DEPTH)) begin
      rd_data <= stamp_mem[scan_cnt[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      stamp_vld        <= '0;
      write_slot       <= '0;
      last_accept_time <= 32'd0;
      accept_total     <= 32'd0;
      m_tvalid         <= 1'b0;
      pend             <= 1'b0;
      rd_vld           <= 1'b0;
      dreq.start       <= 1'b0;
      scan_cnt         <= '0;
    end else begin
      dreq.start <= 1'b0;
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            func  <= s_tuser;
            now   <= s_tdata;
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          accepted <= mem_we;
          if (func == FUNC_CLEAR) begin
            stamp_vld        <= '0;
            write_slot       <= '0;
            last_accept_time <= 32'd0;
            accept_total     <= 32'd0;
          end else if (mem_we) begin
            stamp_vld[write_slot] <= 1'b1;
            last_accept_time      <= now;
            accept_total          <= accept_total + 32'd1;
            write_slot <= (write_slot == IW'(RING_DEPTH - 1)) ? '0 : write_slot + IW'(1);
          end
          scan_cnt <= '0;
          n        <= '0;
          oldest   <= now;
          pend     <= 1'b0;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_cnt < NW'(RING_DEPTH)) begin
            rd_vld   <= stamp_vld[scan_cnt[IW-1:0]];
            pend     <= 1'b1;
            scan_cnt <= scan_cnt + NW'(1);
          end else begin
            pend <= 1'b0;
          end
          if (pend && hit) begin
            n <= n + NW'(1);
            if (rd_data < oldest) begin
              oldest <= rd_data;
            end
          end
          if (scan_cnt == NW'(RING_DEPTH) && !pend) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (n >= NW'(2) && span != 32'd0) begin
            use_div       <= 1'b1;
            dreq.start    <= 1'b1;
            dreq.dividend <= 32'(64'(n - NW'(1)) * 64'(MIN_SCALED));
            dreq.divisor  <= span;
            state         <= ST_DIV;
          end else if (n >= NW'(1) && gap < {12'd0, timeout_ms}) begin
            use_div       <= 1'b1;
            dreq.start    <= 1'b1;
            dreq.dividend <= 32'(64'(n) * 64'(MIN_SCALED));
            dreq.divisor  <= (window_ms == 20'd0) ? 32'd1 : {12'd0, window_ms};
            state         <= ST_DIV;
          end else begin
            use_div <= 1'b0;
            rate    <= 24'd0;
            state   <= ST_FIN;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            rate  <= (div_q > {8'd0, RATE_MAX}) ? RATE_MAX : div_q[23:0];
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, since, in_target, (since > {12'd0, timeout_ms}),
                         (rate > FLOW_LIMIT), rate,
                         (n > NW'(63)) ? 6'd63 : 6'(n), accept_total, accepted};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  drm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

`ifndef SYNTH
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == ST_DIV))
    else $error("divider busy outside the divide step");
  a_accept_upd: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_UPD))
    else $error("accepted transfer did not start an update");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_cnt <= NW'(RING_DEPTH)))
    else $error("scan counter beyond ring depth");
  a_use_div: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FIN) && $past(state) == ST_MUL) |-> !use_div)
    else $error("divide skipped although requested");
`endif

endmodule
